[design/cipt_pkg.sv]
// shared types and constants for the circle tessellator
package cipt_pkg;

    // fixed-point one in Q2.30 and rounding half-lsb for a 30-bit shift
    localparam logic [63:0] Q30_ONE  = 64'd1073741824;
    localparam logic [63:0] Q30_HALF = 64'd536870912;
    // pi in Q2.30
    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    // sum of squared raw normal components below this means a degenerate normal
    localparam logic [63:0] MIN_SQ   = 64'd43;

    typedef logic [31:0] coord_t;

    // one circle after basis construction, as handed from front to back
    typedef struct packed {
        logic [2:0][31:0] cen;
        logic [31:0]      rad;
        logic [2:0][31:0] iv;
        logic [2:0][31:0] jv;
    } basis_t;

endpackage

[design/circle_in_plane_tessellator.sv]
// top level of the circle tessellator
//
// circle channel (circle_valid/circle_ready): one word per circle, giving
// center, plane normal and radius in signed Q16.16. vertex channel
// (vertex_valid/vertex_ready): SEGMENTS+1 words per circle, index 0 first,
// last_vertex set on the closing vertex, which repeats the first point.
// a normal shorter than 0.0001 yields no vertices at all.
// the front builds the unit basis with a shared bit-serial square-root unit
// and a three-lane divider, used in four passes in all; a one-word input buffer
// lets the next circle be taken while one is in work.
// a two-entry queue feeds the back, which issues one vertex per cycle, unless
// the output stalls, into a five-stage multiply pipe.
// the sustained circle rate is set by the front.
// reset clears all control state; no clearing pass is needed.
// when a vertex is waiting and vertex_ready is low the whole back pipe holds; the front keeps
// working until the queue fills, then holds its finished basis.
module circle_in_plane_tessellator #(
    parameter int SEGMENTS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               circle_valid,
    output logic               circle_ready,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic signed [31:0] normal_x,
    input  logic signed [31:0] normal_y,
    input  logic signed [31:0] normal_z,
    input  logic signed [31:0] radius,
    output logic               vertex_valid,
    input  logic               vertex_ready,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic signed [31:0] vertex_z,
    output logic [4:0]         vertex_index,
    output logic               last_vertex
);
    import cipt_pkg::*;

    logic   push_valid;
    logic   push_ready;
    basis_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    basis_t pop_data;

    cipt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .circle_valid (circle_valid),
        .circle_ready (circle_ready),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .radius       (radius),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    cipt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    cipt_back #(
        .SEGMENTS (SEGMENTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_z     (vertex_z),
        .vertex_index (vertex_index),
        .last_vertex  (last_vertex)
    );

endmodule

[design/cipt_sqrt.sv]
// bit-serial 64-bit integer square root, one result bit per cycle
module cipt_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);
    import cipt_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [64:0] trial;

    assign trial = {1'b0, rem_reg} - {1'b0, res_reg + bit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= value;
            res_reg <= 64'd0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_reg <= trial[63:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

[design/cipt_div.sv]
// three-lane restoring divider: round(num * 2^30 / den), one quotient bit per cycle
module cipt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] den,
    input  logic [31:0] num [3],
    output logic        done,
    output logic [31:0] quo [3]
);
    import cipt_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] ds_reg;
    logic [63:0] rem_reg [3];
    logic [31:0] quo_reg [3];
    logic [64:0] trial [3];

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            trial[n] = {1'b0, rem_reg[n]} - {1'b0, ds_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ds_reg <= {1'b0, den, 31'd0};
            for (int n = 0; n < 3; n++)
            begin
                rem_reg[n] <= {2'b00, num[n], 30'd0} + {33'd0, den[31:1]};
                quo_reg[n] <= 32'd0;
            end
        end
        else if (busy_reg)
        begin
            ds_reg <= ds_reg >> 1;
            for (int n = 0; n < 3; n++)
            begin
                if (!trial[n][64])
                begin
                    rem_reg[n] <= trial[n][63:0];
                    quo_reg[n] <= {quo_reg[n][30:0], 1'b1};
                end
                else
                begin
                    quo_reg[n] <= {quo_reg[n][30:0], 1'b0};
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[design/cipt_front.sv]
// front: takes circles, drops degenerate normals, builds the unit basis i, j
module cipt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                circle_valid,
    output logic                circle_ready,
    input  logic signed [31:0]  center_x,
    input  logic signed [31:0]  center_y,
    input  logic signed [31:0]  center_z,
    input  logic signed [31:0]  normal_x,
    input  logic signed [31:0]  normal_y,
    input  logic signed [31:0]  normal_z,
    input  logic signed [31:0]  radius,
    output logic                push_valid,
    input  logic                push_ready,
    output cipt_pkg::basis_t    push_data
);
    import cipt_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RSQ   = 4'd1;
    localparam logic [3:0] ST_RCHK  = 4'd2;
    localparam logic [3:0] ST_NORM  = 4'd3;
    localparam logic [3:0] ST_ESQ   = 4'd4;
    localparam logic [3:0] ST_ESUM  = 4'd5;
    localparam logic [3:0] ST_RSQRT = 4'd6;
    localparam logic [3:0] ST_VDIV  = 4'd7;
    localparam logic [3:0] ST_IV    = 4'd8;
    localparam logic [3:0] ST_ISQ   = 4'd9;
    localparam logic [3:0] ST_ISUM  = 4'd10;
    localparam logic [3:0] ST_ISQRT = 4'd11;
    localparam logic [3:0] ST_IDIV  = 4'd12;
    localparam logic [3:0] ST_JMUL  = 4'd13;
    localparam logic [3:0] ST_JSUM  = 4'd14;
    localparam logic [3:0] ST_PUSH  = 4'd15;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    logic               buf_valid_reg;
    coord_t             buf_cen_reg [3];
    coord_t             buf_nrm_reg [3];
    coord_t             buf_rad_reg;

    logic [3:0]         state_reg;
    coord_t             cen_reg [3];
    coord_t             rad_reg;
    logic               neg_reg [3];
    logic [31:0]        mag_reg [3];
    logic [31:0]        m_reg;
    logic [1:0]         axis_reg;
    logic [63:0]        prod_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [31:0] iv_reg [3];
    logic signed [31:0] i_reg [3];
    logic signed [63:0] jp_reg [6];
    logic signed [31:0] j_reg [3];

    logic [63:0]        sum_sq;
    logic [31:0]        m_max;
    logic [31:0]        iv_mag [3];
    logic [31:0]        buf_mag [3];
    logic signed [64:0] jd [3];

    logic               sqrt_start;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic               div_start;
    logic               div_done;
    logic [31:0]        div_den;
    logic [31:0]        div_num [3];
    logic [31:0]        div_quo [3];

    assign circle_ready = !buf_valid_reg;

    always_comb
    begin
        sum_sq = prod_reg[0] + prod_reg[1] + prod_reg[2];
        m_max  = mag_reg[0];
        if (mag_reg[1] > m_max)
        begin
            m_max = mag_reg[1];
        end
        if (mag_reg[2] > m_max)
        begin
            m_max = mag_reg[2];
        end
        for (int n = 0; n < 3; n++)
        begin
            iv_mag[n]  = iv_reg[n][31] ? 32'(-iv_reg[n]) : 32'(iv_reg[n]);
            buf_mag[n] = buf_nrm_reg[n][31] ? 32'(-buf_nrm_reg[n]) : buf_nrm_reg[n];
        end
        // j = v x i, rounded half up from Q60
        jd[0] = 65'(jp_reg[0]) - 65'(jp_reg[1]) + 65'sd536870912;
        jd[1] = 65'(jp_reg[2]) - 65'(jp_reg[3]) + 65'sd536870912;
        jd[2] = 65'(jp_reg[4]) - 65'(jp_reg[5]) + 65'sd536870912;
    end

    assign sqrt_start = state_reg inside {ST_ESUM, ST_ISUM};
    assign div_start  = sqrt_done && (state_reg inside {ST_RSQRT, ST_ISQRT});
    assign div_den    = (sqrt_root == 32'd0) ? 32'd1 : sqrt_root;

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            div_num[n] = (state_reg == ST_RSQRT) ? mag_reg[n] : iv_mag[n];
        end
    end

    cipt_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sum_sq),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    cipt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (div_den),
        .num   (div_num),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            state_reg     <= ST_IDLE;
        end
        else
        begin
            if (circle_valid && circle_ready)
            begin
                buf_valid_reg <= 1'b1;
            end
            else if (state_reg == ST_IDLE && buf_valid_reg)
            begin
                buf_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (buf_valid_reg)
                    begin
                        state_reg <= ST_RSQ;
                    end
                end
                ST_RSQ:   state_reg <= ST_RCHK;
                ST_RCHK:  state_reg <= (sum_sq < MIN_SQ) ? ST_IDLE : ST_NORM;
                ST_NORM:
                begin
                    if (m_reg[31:30] != 2'b00)
                    begin
                        state_reg <= ST_ESQ;
                    end
                end
                ST_ESQ:   state_reg <= ST_ESUM;
                ST_ESUM:  state_reg <= ST_RSQRT;
                ST_RSQRT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= ST_VDIV;
                    end
                end
                ST_VDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_IV;
                    end
                end
                ST_IV:    state_reg <= ST_ISQ;
                ST_ISQ:   state_reg <= ST_ISUM;
                ST_ISUM:  state_reg <= ST_ISQRT;
                ST_ISQRT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= ST_IDIV;
                    end
                end
                ST_IDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_JMUL;
                    end
                end
                ST_JMUL:  state_reg <= ST_JSUM;
                ST_JSUM:  state_reg <= ST_PUSH;
                ST_PUSH:
                begin
                    if (push_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (circle_valid && circle_ready)
        begin
            buf_cen_reg[0] <= center_x;
            buf_cen_reg[1] <= center_y;
            buf_cen_reg[2] <= center_z;
            buf_nrm_reg[0] <= normal_x;
            buf_nrm_reg[1] <= normal_y;
            buf_nrm_reg[2] <= normal_z;
            buf_rad_reg    <= radius;
        end

        case (state_reg)
            ST_IDLE:
            begin
                rad_reg <= buf_rad_reg;
                for (int n = 0; n < 3; n++)
                begin
                    cen_reg[n] <= buf_cen_reg[n];
                    neg_reg[n] <= buf_nrm_reg[n][31];
                    mag_reg[n] <= buf_mag[n];
                end
            end
            ST_RSQ, ST_ESQ:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    prod_reg[n] <= 64'(mag_reg[n]) * 64'(mag_reg[n]);
                end
            end
            ST_RCHK:
            begin
                m_reg <= m_max;
                // smallest magnitude picks the axis, ties to x then y
                if (mag_reg[0] <= mag_reg[1] && mag_reg[0] <= mag_reg[2])
                begin
                    axis_reg <= AXIS_X;
                end
                else if (mag_reg[1] <= mag_reg[2] && mag_reg[1] <= mag_reg[0])
                begin
                    axis_reg <= AXIS_Y;
                end
                else
                begin
                    axis_reg <= AXIS_Z;
                end
            end
            ST_NORM:
            begin
                // bring the largest component up to 2^30 or more
                if (m_reg[31:22] == 10'd0)
                begin
                    m_reg <= m_reg << 8;
                    for (int n = 0; n < 3; n++)
                    begin
                        mag_reg[n] <= mag_reg[n] << 8;
                    end
                end
                else if (m_reg[31:30] == 2'b00)
                begin
                    m_reg <= m_reg << 1;
                    for (int n = 0; n < 3; n++)
                    begin
                        mag_reg[n] <= mag_reg[n] << 1;
                    end
                end
            end
            ST_VDIV:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    v_reg[n] <= neg_reg[n] ? -$signed(div_quo[n]) : $signed(div_quo[n]);
                end
            end
            ST_IV:
            begin
                case (axis_reg)
                    AXIS_X:
                    begin
                        iv_reg[0] <= 32'sd0;
                        iv_reg[1] <= v_reg[2];
                        iv_reg[2] <= -v_reg[1];
                    end
                    AXIS_Y:
                    begin
                        iv_reg[0] <= -v_reg[2];
                        iv_reg[1] <= 32'sd0;
                        iv_reg[2] <= v_reg[0];
                    end
                    default:
                    begin
                        iv_reg[0] <= v_reg[1];
                        iv_reg[1] <= -v_reg[0];
                        iv_reg[2] <= 32'sd0;
                    end
                endcase
            end
            ST_ISQ:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    prod_reg[n] <= 64'(iv_mag[n]) * 64'(iv_mag[n]);
                end
            end
            ST_IDIV:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    i_reg[n] <= iv_reg[n][31] ? -$signed(div_quo[n]) : $signed(div_quo[n]);
                end
            end
            ST_JMUL:
            begin
                jp_reg[0] <= v_reg[1] * i_reg[2];
                jp_reg[1] <= v_reg[2] * i_reg[1];
                jp_reg[2] <= v_reg[2] * i_reg[0];
                jp_reg[3] <= v_reg[0] * i_reg[2];
                jp_reg[4] <= v_reg[0] * i_reg[1];
                jp_reg[5] <= v_reg[1] * i_reg[0];
            end
            ST_JSUM:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    j_reg[n] <= jd[n][61:30];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign push_valid = (state_reg == ST_PUSH);

    always_comb
    begin
        push_data.rad = rad_reg;
        for (int n = 0; n < 3; n++)
        begin
            push_data.cen[n] = cen_reg[n];
            push_data.iv[n]  = i_reg[n];
            push_data.jv[n]  = j_reg[n];
        end
    end

endmodule

[design/cipt_fifo.sv]
// short queue of finished circle bases between front and back
module cipt_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  cipt_pkg::basis_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output cipt_pkg::basis_t pop_data
);
    import cipt_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    basis_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != (PW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/cipt_back.sv]
// back: walks the circle, one vertex per cycle unless the output stalls, through a five-stage pipe
module cipt_back #(
    parameter int SEGMENTS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  cipt_pkg::basis_t   pop_data,
    output logic               vertex_valid,
    input  logic               vertex_ready,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic signed [31:0] vertex_z,
    output logic [4:0]         vertex_index,
    output logic               last_vertex
);
    import cipt_pkg::*;

    localparam int KW = $clog2(SEGMENTS + 1);

    // cos and sin of k*2pi/SEGMENTS in Q2.30, packed {cos, sin}
    function automatic logic [63:0] sincos_of(input int kk);
        logic [63:0] ph;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] c;
        logic [1:0]  quad;
        logic        upper;
        logic [31:0] s0;
        logic [31:0] c0;
        logic [31:0] cs;
        logic [31:0] sn;
        ph = ((64'(kk) << 32) + 64'(SEGMENTS / 2)) / SEGMENTS;
        quad  = ph[31:30];
        r     = {34'd0, ph[29:0]};
        upper = r > Q30_HALF;
        a     = upper ? Q30_ONE - r : r;
        x     = (a * PI_Q30 + Q30_ONE) >> 31;
        x2    = (x * x + Q30_HALF) >> 30;
        t = Q30_ONE;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s = (x * t) >> 30;
        t = Q30_ONE;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd132;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd90;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd2;
        c = t;
        if (upper)
        begin
            c0 = s[31:0];
            s0 = c[31:0];
        end
        else
        begin
            c0 = c[31:0];
            s0 = s[31:0];
        end
        case (quad)
            2'd0:
            begin
                cs = c0;
                sn = s0;
            end
            2'd1:
            begin
                cs = -s0;
                sn = c0;
            end
            2'd2:
            begin
                cs = -c0;
                sn = -s0;
            end
            default:
            begin
                cs = s0;
                sn = -c0;
            end
        endcase
        return {cs, sn};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] o;
        if (v > 38'sd2147483647)
        begin
            o = 32'sh7fffffff;
        end
        else if (v < -38'sd2147483648)
        begin
            o = 32'sh80000000;
        end
        else
        begin
            o = v[31:0];
        end
        return o;
    endfunction

    logic [63:0] sc_tab [SEGMENTS+1];

    for (genvar g = 0; g <= SEGMENTS; g++)
    begin : g_tab
        assign sc_tab[g] = sincos_of(g);
    end

    basis_t             cur_reg;
    logic               cur_valid_reg;
    logic [KW-1:0]      k_reg;
    logic               adv;
    logic               issue;
    logic               last_k;
    logic               pop;

    logic               s1_valid_reg;
    logic signed [31:0] s1_cs_reg;
    logic signed [31:0] s1_sn_reg;
    basis_t             s1_b_reg;
    logic [4:0]         s1_idx_reg;
    logic               s1_last_reg;

    logic               s2_valid_reg;
    logic signed [63:0] pc_reg [3];
    logic signed [63:0] ps_reg [3];
    coord_t             s2_cen_reg [3];
    logic signed [31:0] s2_rad_reg;
    logic [4:0]         s2_idx_reg;
    logic               s2_last_reg;

    logic               s3_valid_reg;
    logic signed [33:0] w_reg [3];
    coord_t             s3_cen_reg [3];
    logic signed [31:0] s3_rad_reg;
    logic [4:0]         s3_idx_reg;
    logic               s3_last_reg;

    logic               s4_valid_reg;
    logic signed [65:0] wr_reg [3];
    coord_t             s4_cen_reg [3];
    logic [4:0]         s4_idx_reg;
    logic               s4_last_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_reg [3];
    logic [4:0]         out_idx_reg;
    logic               out_last_reg;

    logic signed [64:0] ws [3];
    logic signed [66:0] offr [3];
    logic signed [37:0] tot [3];

    assign adv       = !out_valid_reg || vertex_ready;
    assign issue     = cur_valid_reg && adv;
    assign last_k    = (k_reg == KW'(SEGMENTS));
    assign pop_ready = !cur_valid_reg || (issue && last_k);
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            ws[n]   = 65'(pc_reg[n]) + 65'(ps_reg[n]) + 65'sd536870912;
            offr[n] = 67'(wr_reg[n]) + 67'sd536870912;
            tot[n]  = 38'($signed(s4_cen_reg[n])) + 38'($signed(offr[n][65:30]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
            end
            else if (issue && last_k)
            begin
                cur_valid_reg <= 1'b0;
            end
            if (issue)
            begin
                k_reg <= last_k ? '0 : k_reg + 1'b1;
            end
            if (adv)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_data;
        end
        if (adv)
        begin
            s1_cs_reg   <= $signed(sc_tab[k_reg][63:32]);
            s1_sn_reg   <= $signed(sc_tab[k_reg][31:0]);
            s1_b_reg    <= cur_reg;
            s1_idx_reg  <= 5'(k_reg);
            s1_last_reg <= last_k;

            for (int n = 0; n < 3; n++)
            begin
                pc_reg[n]     <= s1_cs_reg * $signed(s1_b_reg.iv[n]);
                ps_reg[n]     <= s1_sn_reg * $signed(s1_b_reg.jv[n]);
                s2_cen_reg[n] <= s1_b_reg.cen[n];
                w_reg[n]      <= ws[n][63:30];
                s3_cen_reg[n] <= s2_cen_reg[n];
                wr_reg[n]     <= w_reg[n] * s3_rad_reg;
                s4_cen_reg[n] <= s3_cen_reg[n];
                out_reg[n]    <= sat32(tot[n]);
            end
            s2_rad_reg   <= $signed(s1_b_reg.rad);
            s2_idx_reg   <= s1_idx_reg;
            s2_last_reg  <= s1_last_reg;
            s3_rad_reg   <= s2_rad_reg;
            s3_idx_reg   <= s2_idx_reg;
            s3_last_reg  <= s2_last_reg;
            s4_idx_reg   <= s3_idx_reg;
            s4_last_reg  <= s3_last_reg;
            out_idx_reg  <= s4_idx_reg;
            out_last_reg <= s4_last_reg;
        end
    end

    assign vertex_valid = out_valid_reg;
    assign vertex_x     = out_reg[0];
    assign vertex_y     = out_reg[1];
    assign vertex_z     = out_reg[2];
    assign vertex_index = out_idx_reg;
    assign last_vertex  = out_last_reg;

endmodule

[design/cipt_checker.sv]
// port-level checks on the vertex stream, bound to the top level
module cipt_checker #(
    parameter int SEGMENTS = 30
) (
    input logic        clk,
    input logic        rst_n,
    input logic        vertex_valid,
    input logic        vertex_ready,
    input logic [31:0] vertex_x,
    input logic [4:0]  vertex_index,
    input logic        last_vertex
);

    // a stalled word holds its index and x coordinate
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && !vertex_ready |=>
        vertex_valid && $stable(vertex_index) && $stable(vertex_x))
        else $error("vertex word changed while stalled");

    // closing vertex carries the segment count
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && last_vertex |-> vertex_index == 5'(SEGMENTS))
        else $error("closing vertex has wrong index");

    // vertices within a run come in order
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_ready && !last_vertex |=>
        !vertex_valid || vertex_index == 5'($past(vertex_index) + 5'd1))
        else $error("vertex index skipped");

    // a new run starts at index zero
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_ready && last_vertex |=>
        !vertex_valid || vertex_index == 5'd0)
        else $error("run did not restart at zero");

endmodule

bind circle_in_plane_tessellator cipt_checker #(.SEGMENTS(SEGMENTS)) u_cipt_checker (.*);
